@@ rtl/core/ipfd_pkg.sv @@
package ipfd_pkg;

  // configuration register file
  localparam int unsigned NUM_CFG = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HMARK_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HMARK_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HSPACE_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BMARK_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BMARK_MAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BSPACE_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BSPACE_MAX = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LIM   = 3'd7;

  localparam logic [CFG_W-1:0] HMARK_MIN_RST  = 16'd8000;
  localparam logic [CFG_W-1:0] HMARK_MAX_RST  = 16'd10000;
  localparam logic [CFG_W-1:0] HSPACE_MAX_RST = 16'd9000;
  localparam logic [CFG_W-1:0] BMARK_MIN_RST  = 16'd360;
  localparam logic [CFG_W-1:0] BMARK_MAX_RST  = 16'd760;
  localparam logic [CFG_W-1:0] BSPACE_MIN_RST = 16'd360;
  localparam logic [CFG_W-1:0] BSPACE_MAX_RST = 16'd1980;
  localparam logic [CFG_W-1:0] ZERO_LIM_RST   = 16'd760;

  localparam logic LEVEL_MARK  = 1'b0;
  localparam logic LEVEL_SPACE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HSPACE = 2'd1,
    PH_MARK   = 2'd2,
    PH_SPACE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_GOOD   = 2'd1,
    ST_TIMING = 2'd2,
    ST_CHECK  = 2'd3
  } status_t;

  typedef struct packed {
    logic [CFG_W-1:0] hmark_min;
    logic [CFG_W-1:0] hmark_max;
    logic [CFG_W-1:0] hspace_max;
    logic [CFG_W-1:0] bmark_min;
    logic [CFG_W-1:0] bmark_max;
    logic [CFG_W-1:0] bspace_min;
    logic [CFG_W-1:0] bspace_max;
    logic [CFG_W-1:0] zero_lim;
  } cfg_t;

  // window checks on one pulse, level folded into every check but bit_zero
  typedef struct packed {
    logic is_mark;
    logic hmark_ok;
    logic hspace_ok;
    logic bmark_ok;
    logic bspace_ok;
    logic bit_zero;
  } pulse_cls_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  cmd;
    logic [7:0]  addr;
  } frame_res_t;

endpackage

@@ rtl/core/ipfd_cfg.sv @@
module ipfd_cfg
  import ipfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hmark_min  <= HMARK_MIN_RST;
      cfg.hmark_max  <= HMARK_MAX_RST;
      cfg.hspace_max <= HSPACE_MAX_RST;
      cfg.bmark_min  <= BMARK_MIN_RST;
      cfg.bmark_max  <= BMARK_MAX_RST;
      cfg.bspace_min <= BSPACE_MIN_RST;
      cfg.bspace_max <= BSPACE_MAX_RST;
      cfg.zero_lim   <= ZERO_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HMARK_MIN:  cfg.hmark_min  <= cfg_data;
        CFG_HMARK_MAX:  cfg.hmark_max  <= cfg_data;
        CFG_HSPACE_MAX: cfg.hspace_max <= cfg_data;
        CFG_BMARK_MIN:  cfg.bmark_min  <= cfg_data;
        CFG_BMARK_MAX:  cfg.bmark_max  <= cfg_data;
        CFG_BSPACE_MIN: cfg.bspace_min <= cfg_data;
        CFG_BSPACE_MAX: cfg.bspace_max <= cfg_data;
        CFG_ZERO_LIM:   cfg.zero_lim   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/ipfd_classify.sv @@
module ipfd_classify
  import ipfd_pkg::*;
(
  input  cfg_t             cfg,
  input  logic             level,
  input  logic [CFG_W-1:0] length,
  output pulse_cls_t       cls
);

  logic is_mark;
  logic is_space;

  assign is_mark  = (level == LEVEL_MARK);
  assign is_space = (level == LEVEL_SPACE);

  // all windows inclusive; the zero band is exclusive on both ends
  always_comb begin
    cls.is_mark   = is_mark;
    cls.hmark_ok  = is_mark && (length >= cfg.hmark_min) && (length <= cfg.hmark_max);
    cls.hspace_ok = is_space && (length <= cfg.hspace_max);
    cls.bmark_ok  = is_mark && (length >= cfg.bmark_min) && (length <= cfg.bmark_max);
    cls.bspace_ok = is_space && (length >= cfg.bspace_min) && (length <= cfg.bspace_max);
    cls.bit_zero  = (length > cfg.bspace_min) && (length < cfg.zero_lim);
  end

endmodule

@@ rtl/core/ipfd_frame.sv @@
module ipfd_frame
  import ipfd_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  pulse_cls_t cls,
  output frame_res_t res
);

  localparam int unsigned CNT_W  = $clog2(FRAME_BITS + 1);
  localparam int unsigned WORD_W = (FRAME_BITS > 32) ? FRAME_BITS : 32;

  phase_t                phase, phase_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [FRAME_BITS-1:0] shift_word, shift_word_next;

  logic [FRAME_BITS-1:0] shifted;
  logic [WORD_W-1:0]     padded;
  logic                  last_bit;
  logic                  check_ok;

  // newest bit enters at the top, so the first bit ends in bit 0
  assign shifted  = {~cls.bit_zero, shift_word[FRAME_BITS-1:1]};
  assign padded   = WORD_W'(shifted);
  assign last_bit = (count == CNT_W'(FRAME_BITS - 1));
  assign check_ok = (padded[7:0] == ~padded[15:8]) && (padded[23:16] == ~padded[31:24]);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      count      <= '0;
      shift_word <= '0;
    end else begin
      phase      <= phase_next;
      count      <= count_next;
      shift_word <= shift_word_next;
    end
  end

  // next state
  always_comb begin
    phase_next      = phase;
    count_next      = count;
    shift_word_next = shift_word;
    if (step) begin
      unique case (phase)
        PH_IDLE: begin
          if (cls.hmark_ok) begin
            phase_next      = PH_HSPACE;
            count_next      = '0;
            shift_word_next = '0;
          end
        end
        PH_HSPACE: begin
          if (cls.hspace_ok) begin
            phase_next = PH_MARK;
          end else begin
            phase_next      = PH_IDLE;
            count_next      = '0;
            shift_word_next = '0;
          end
        end
        PH_MARK: begin
          if (cls.bmark_ok) begin
            phase_next = PH_SPACE;
          end else begin
            phase_next      = PH_IDLE;
            count_next      = '0;
            shift_word_next = '0;
          end
        end
        PH_SPACE: begin
          if (cls.bspace_ok && !last_bit) begin
            phase_next      = PH_MARK;
            count_next      = count + 1'b1;
            shift_word_next = shifted;
          end else begin
            phase_next      = PH_IDLE;
            count_next      = '0;
            shift_word_next = '0;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // result for the current pulse
  always_comb begin
    res.status = ST_BUSY;
    res.addr   = '0;
    res.cmd    = '0;
    unique case (phase)
      PH_IDLE: begin
        if (cls.is_mark && !cls.hmark_ok) res.status = ST_TIMING;
      end
      PH_HSPACE: begin
        if (!cls.hspace_ok) res.status = ST_TIMING;
      end
      PH_MARK: begin
        if (!cls.bmark_ok) res.status = ST_TIMING;
      end
      PH_SPACE: begin
        if (!cls.bspace_ok) begin
          res.status = ST_TIMING;
        end else if (last_bit) begin
          if (check_ok) begin
            res.status = ST_GOOD;
            res.addr   = padded[7:0];
            res.cmd    = padded[23:16];
          end else begin
            res.status = ST_CHECK;
          end
        end
      end
      default: res.status = ST_BUSY;
    endcase
  end

endmodule

@@ rtl/core/ir_pulse_frame_decoder.sv @@
// ir pulse frame decoder: takes one measured line level per item (level in tuser,
// length in microseconds in tdata) and decodes remote-control frames of a
// header mark, a header space and FRAME_BITS data bits sent lsb first, every
// length checked against a programmable window. every input item gives exactly
// one output item: status 0 while a frame is in progress or the line idles,
// 1 for a good frame (address and command bytes valid), 2 for a timing or
// level error, 3 when address or command fails its complement check. a pulse
// is registered on entry, decoded combinationally from the input register and
// written to an output register, where its result is offered; one item can be
// taken every cycle; only a stalled output holds the input back. the user must
// write the window registers through the cfg port only while no item is in flight
// (the block does not enforce it); they reset to the usual remote-control timings
module ir_pulse_frame_decoder
  import ipfd_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,

  // pulse items in
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // [15:0] pulse_length
  input  logic                 s_tuser,   // [0] pulse_level

  // frame result items out
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // [7:0] address_byte, [15:8] command_byte
  output logic [1:0]           m_tuser,   // [1:0] frame_status

  // window register writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t       cfg;
  pulse_cls_t cls;
  frame_res_t res;

  // input register
  logic             in_valid;
  logic             in_level;
  logic [CFG_W-1:0] in_length;

  // the decode stage advances whenever it holds an item and the output register is free or emptying
  logic out_free;
  logic step;

  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  ipfd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_level  <= s_tuser;
      in_length <= s_tdata;
    end
  end

  // window compares on the registered pulse
  ipfd_classify u_classify (
    .cfg    (cfg),
    .level  (in_level),
    .length (in_length),
    .cls    (cls)
  );

  // phase tracking, bit shifting and the end-of-frame check
  ipfd_frame #(
    .FRAME_BITS (FRAME_BITS)
  ) u_frame (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cls  (cls),
    .res  (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {res.cmd, res.addr};
      m_tuser <= res.status;
    end
  end

endmodule

@@ dv/tb_ir_pulse_frame_decoder.sv @@
`timescale 1ns / 1ps

module tb_ir_pulse_frame_decoder;
  import ipfd_pkg::*;

  localparam int unsigned FRAME_BITS  = 32;
  localparam int          QUIET_LIMIT = 4000;  // cycles with no item moving on either side

  // frame decoder predictor and the queue of frame results it expects
  class frame_scoreboard;
    cfg_t        win;
    phase_t      ph;
    logic [5:0]  nbits;
    logic [31:0] frame_word;
    frame_res_t  expected_frames[$];
    int          errors;

    function new();
      win = '{hmark_min: HMARK_MIN_RST, hmark_max: HMARK_MAX_RST,
              hspace_max: HSPACE_MAX_RST, bmark_min: BMARK_MIN_RST,
              bmark_max: BMARK_MAX_RST, bspace_min: BSPACE_MIN_RST,
              bspace_max: BSPACE_MAX_RST, zero_lim: ZERO_LIM_RST};
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      ph         = PH_IDLE;
      nbits      = '0;
      frame_word = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_HMARK_MIN:  win.hmark_min  = val;
        CFG_HMARK_MAX:  win.hmark_max  = val;
        CFG_HSPACE_MAX: win.hspace_max = val;
        CFG_BMARK_MIN:  win.bmark_min  = val;
        CFG_BMARK_MAX:  win.bmark_max  = val;
        CFG_BSPACE_MIN: win.bspace_min = val;
        CFG_BSPACE_MAX: win.bspace_max = val;
        CFG_ZERO_LIM:   win.zero_lim   = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    // advance the decoder by one pulse and queue the result it gives
    function void note_pulse(logic lvl, logic [15:0] len);
      frame_res_t res;
      logic       is_zero;
      res = '{status: ST_BUSY, cmd: 8'h00, addr: 8'h00};
      case (ph)
        PH_IDLE: begin
          // idle line spaces are ignored
          if (lvl == LEVEL_MARK) begin
            if (len >= win.hmark_min && len <= win.hmark_max) begin
              clear_frame();
              ph = PH_HSPACE;
            end else begin
              res.status = ST_TIMING;
            end
          end
        end
        PH_HSPACE: begin
          if (lvl == LEVEL_SPACE && len <= win.hspace_max) begin
            ph = PH_MARK;
          end else begin
            res.status = ST_TIMING;
            clear_frame();
          end
        end
        PH_MARK: begin
          if (lvl == LEVEL_MARK && len >= win.bmark_min && len <= win.bmark_max) begin
            ph = PH_SPACE;
          end else begin
            res.status = ST_TIMING;
            clear_frame();
          end
        end
        default: begin
          if (lvl == LEVEL_SPACE && len >= win.bspace_min && len <= win.bspace_max) begin
            is_zero    = (len > win.bspace_min) && (len < win.zero_lim);
            frame_word = {~is_zero, frame_word[31:1]};
            nbits      = nbits + 6'd1;
            if (nbits >= FRAME_BITS) begin
              if (frame_word[7:0] == ~frame_word[15:8] &&
                  frame_word[23:16] == ~frame_word[31:24]) begin
                res.status = ST_GOOD;
                res.addr   = frame_word[7:0];
                res.cmd    = frame_word[23:16];
              end else begin
                res.status = ST_CHECK;
              end
              clear_frame();
            end else begin
              ph = PH_MARK;
            end
          end else begin
            res.status = ST_TIMING;
            clear_frame();
          end
        end
      endcase
      expected_frames.push_back(res);
    endfunction

    function void check_result(logic [1:0] st, logic [15:0] data);
      frame_res_t exp_res;
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, status %0d data %h", $time, st, data);
        return;
      end
      exp_res = expected_frames.pop_front();
      if (exp_res.status != st) begin
        errors++;
        $display("%0t: frame_status expected %0d actual %0d", $time, exp_res.status, st);
      end
      if (exp_res.addr != data[7:0]) begin
        errors++;
        $display("%0t: address_byte expected %h actual %h", $time, exp_res.addr, data[7:0]);
      end
      if (exp_res.cmd != data[15:8]) begin
        errors++;
        $display("%0t: command_byte expected %h actual %h", $time, exp_res.cmd, data[15:8]);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;
  logic [1:0]           m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  frame_scoreboard sb = new();

  int pulses_sent  = 0;
  int burst_left   = 1;
  int stall_mode   = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;

  ir_pulse_frame_decoder #(.FRAME_BITS(FRAME_BITS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // handshakes and register writes are sampled at the edge, before any update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_pulse(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // receiver back-pressure: each stretch picks one of a few stall patterns
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;                          // no stalls at all
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 4) == 0);   // mostly stalled
      default: m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // watchdog: give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_ir_pulse_frame_decoder: FAIL");
      $finish;
    end
  end

  // present one pulse and hold it until taken; bursts end in a random gap, sometimes none
  task automatic send_pulse(input logic lvl, input int len);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= lvl;
    s_tdata  <= 16'(len);
    do @(posedge clk); while (!s_tready);
    pulses_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending and wait until every queued result has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_windows(input cfg_t w);
    logic [CFG_W-1:0] vals [NUM_CFG];
    vals[CFG_HMARK_MIN]  = w.hmark_min;
    vals[CFG_HMARK_MAX]  = w.hmark_max;
    vals[CFG_HSPACE_MAX] = w.hspace_max;
    vals[CFG_BMARK_MIN]  = w.bmark_min;
    vals[CFG_BMARK_MAX]  = w.bmark_max;
    vals[CFG_BSPACE_MIN] = w.bspace_min;
    vals[CFG_BSPACE_MAX] = w.bspace_max;
    vals[CFG_ZERO_LIM]   = w.zero_lim;
    for (int i = 0; i < NUM_CFG; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // length inside lo..hi, often right on a bound; anything at all if the window is empty
  function automatic int pick_in(int lo, int hi);
    int r;
    if (lo > hi) return $urandom_range(0, 65535);
    r = $urandom_range(0, 3);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  // length outside lo..hi, often just past a bound; anything if the window is empty, -1 if it covers every length
  function automatic int pick_out(int lo, int hi);
    if (lo > hi) return $urandom_range(0, 65535);
    if (hi < 65535 && (lo == 0 || $urandom_range(0, 1) == 0))
      return ($urandom_range(0, 1) == 0) ? hi + 1 : $urandom_range(65535, hi + 1);
    if (lo > 0)
      return ($urandom_range(0, 1) == 0) ? lo - 1 : $urandom_range(0, lo - 1);
    return -1;
  endfunction

  // data space that decodes to the wanted bit where the windows allow it
  function automatic int space_for(logic b);
    int lo, hi, zl, zero_hi, ones_lo;
    lo = sb.win.bspace_min;
    hi = sb.win.bspace_max;
    zl = sb.win.zero_lim;
    zero_hi = (zl - 1 < hi) ? zl - 1 : hi;
    ones_lo = (zl > lo) ? zl : lo;
    if (!b && lo + 1 <= zero_hi) return pick_in(lo + 1, zero_hi);
    if (b && ones_lo <= hi && $urandom_range(0, 3) != 0) return pick_in(ones_lo, hi);
    if (b && lo <= hi) return lo;  // a space right at the minimum is a one
    return pick_in(lo, hi);
  endfunction

  // one frame: header mark, header space, then a mark and a space per bit, lsb first;
  // at pulse break_at a wrong level or length goes out instead and the frame stops
  task automatic send_frame(input logic [31:0] word, input int break_at);
    logic lvl;
    int   len, lo, hi;
    for (int i = 0; i < 2 + 2 * FRAME_BITS; i++) begin
      lvl = (i % 2 == 0) ? LEVEL_MARK : LEVEL_SPACE;
      if (i == 0) begin
        lo = sb.win.hmark_min; hi = sb.win.hmark_max;
      end else if (i == 1) begin
        lo = 0; hi = sb.win.hspace_max;
      end else if (lvl == LEVEL_MARK) begin
        lo = sb.win.bmark_min; hi = sb.win.bmark_max;
      end else begin
        lo = sb.win.bspace_min; hi = sb.win.bspace_max;
      end
      if (i == break_at) begin
        len = pick_out(lo, hi);
        if (len < 0 || $urandom_range(0, 2) == 0) begin
          lvl = ~lvl;
          len = $urandom_range(0, 65535);
        end
        send_pulse(lvl, len);
        return;
      end
      if (i >= 2 && lvl == LEVEL_SPACE) len = space_for(word[(i - 3) / 2]);
      else len = pick_in(lo, hi);
      send_pulse(lvl, len);
    end
  endtask

  task automatic run_random(input int n_pulses);
    int          stop_at, r;
    logic [7:0]  addr, cmd;
    logic [31:0] word;
    stop_at = pulses_sent + n_pulses;
    while (pulses_sent < stop_at) begin
      r    = $urandom_range(0, 99);
      addr = 8'($urandom);
      cmd  = 8'($urandom);
      word = {~cmd, cmd, ~addr, addr};
      if ($urandom_range(0, 3) == 0) send_pulse(LEVEL_SPACE, $urandom_range(0, 65535));
      if (r < 60) begin
        send_frame(word, -1);
      end else if (r < 72) begin
        // complement check fails for a flipped bit, and almost always for an arbitrary word
        if ($urandom_range(0, 1) == 0) word[$urandom_range(0, 31)] ^= 1'b1;
        else word = $urandom;
        send_frame(word, -1);
      end else if (r < 88) begin
        send_frame(word, $urandom_range(0, 1 + 2 * FRAME_BITS));
      end else begin
        repeat ($urandom_range(1, 8))
          send_pulse(1'($urandom_range(0, 1)), $urandom_range(0, 65535));
      end
    end
  endtask

  function automatic cfg_t random_windows();
    cfg_t w;
    w.hmark_min  = 16'($urandom_range(0, 20000));
    w.hmark_max  = 16'(w.hmark_min + $urandom_range(0, 20000));
    w.hspace_max = 16'($urandom_range(0, 65535));
    w.bmark_min  = 16'($urandom_range(0, 2000));
    w.bmark_max  = 16'(w.bmark_min + $urandom_range(0, 3000));
    w.bspace_min = 16'($urandom_range(0, 2000));
    w.bspace_max = 16'(w.bspace_min + $urandom_range(0, 4000));
    w.zero_lim   = 16'($urandom_range(w.bspace_max, w.bspace_min));
    return w;
  endfunction

  initial begin
    cfg_t w;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset windows
    send_pulse(LEVEL_SPACE, 65535);  // idle line, ignored
    send_pulse(LEVEL_MARK, 0);       // header mark far too short
    send_pulse(LEVEL_MARK, 65535);   // and far too long
    send_pulse(LEVEL_MARK, 7999);
    send_pulse(LEVEL_MARK, 10001);
    send_pulse(LEVEL_MARK, 8000);    // header just outside both window bounds, then at the minimum
    send_pulse(LEVEL_SPACE, 0);
    send_pulse(LEVEL_MARK, 360);
    send_pulse(LEVEL_SPACE, 360);    // space at the minimum is a one
    send_pulse(LEVEL_MARK, 760);
    send_pulse(LEVEL_SPACE, 361);    // just above the minimum is a zero
    send_pulse(LEVEL_MARK, 500);
    send_pulse(LEVEL_SPACE, 1980);
    send_pulse(LEVEL_MARK, 500);
    send_pulse(LEVEL_SPACE, 1981);   // bit space too long
    send_pulse(LEVEL_MARK, 10000);
    send_pulse(LEVEL_SPACE, 9000);
    send_pulse(LEVEL_MARK, 359);     // bit mark too short
    send_pulse(LEVEL_MARK, 9000);
    send_pulse(LEVEL_MARK, 9000);    // mark where the header space belongs
    send_pulse(LEVEL_MARK, 9000);
    send_pulse(LEVEL_SPACE, 4500);
    send_pulse(LEVEL_SPACE, 560);    // space where a bit mark belongs
    send_pulse(LEVEL_MARK, 9000);
    send_pulse(LEVEL_SPACE, 4500);
    send_pulse(LEVEL_MARK, 560);
    send_pulse(LEVEL_MARK, 560);     // mark where a bit space belongs
    run_random(300);

    // widest windows: every length fits, zero spaces fill 1..65534
    drain();
    w = '{hmark_min: 16'd0, hmark_max: 16'hffff, hspace_max: 16'hffff,
          bmark_min: 16'd0, bmark_max: 16'hffff, bspace_min: 16'd0,
          bspace_max: 16'hffff, zero_lim: 16'hffff};
    program_windows(w);
    run_random(300);

    // single-value mark windows
    drain();
    w = '{hmark_min: 16'd9000, hmark_max: 16'd9000, hspace_max: 16'd4500,
          bmark_min: 16'd560, bmark_max: 16'd560, bspace_min: 16'd560,
          bspace_max: 16'd1690, zero_lim: 16'd1125};
    program_windows(w);
    run_random(300);

    // bit space window empty, no zero band, header space of zero only
    drain();
    w = '{hmark_min: 16'd0, hmark_max: 16'd0, hspace_max: 16'd0,
          bmark_min: 16'd200, bmark_max: 16'd1000, bspace_min: 16'd2000,
          bspace_max: 16'd1000, zero_lim: 16'd0};
    program_windows(w);
    run_random(100);

    // header mark window empty: nothing gets past idle
    drain();
    w = '{hmark_min: 16'hffff, hmark_max: 16'hfffe, hspace_max: 16'd9000,
          bmark_min: 16'hffff, bmark_max: 16'hffff, bspace_min: 16'hffff,
          bspace_max: 16'hffff, zero_lim: 16'hffff};
    program_windows(w);
    run_random(80);

    drain();
    program_windows(random_windows());
    run_random(150);
    drain();
    program_windows(random_windows());
    run_random(150);

    // back to the usual timings
    drain();
    w = '{hmark_min: HMARK_MIN_RST, hmark_max: HMARK_MAX_RST,
          hspace_max: HSPACE_MAX_RST, bmark_min: BMARK_MIN_RST,
          bmark_max: BMARK_MAX_RST, bspace_min: BSPACE_MIN_RST,
          bspace_max: BSPACE_MAX_RST, zero_lim: ZERO_LIM_RST};
    program_windows(w);
    run_random(250);

    // let the pipeline empty, then watch a little longer for stray results
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_ir_pulse_frame_decoder: PASS");
    else
      $display("tb_ir_pulse_frame_decoder: FAIL");
    $finish;
  end

endmodule
